/* rtl/bis_pkg.sv */
// Package for the bilinear image scaler: sizes, widths, register indexes, shared types.
// No dependencies.
`default_nettype none
package bis_pkg;
    localparam int MAX_SRC_WIDTH  = 512;
    localparam int MAX_SRC_HEIGHT = 512;
    localparam int FRAC_BITS      = 8;
    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);
    localparam int AW = XW + YW;
    localparam int CW = 12;
    localparam int SWW = 10;
    localparam int DWW = 12;
    // dividend x*s*2^F fits CW+13+F bits; a divisor of 1 passes it through whole,
    // so the quotient needs the full dividend width
    localparam int NW = CW + 13 + FRAC_BITS;
    localparam int QW = NW;

    localparam logic [1:0] REG_SRC_W = 2'd0;
    localparam logic [1:0] REG_SRC_H = 2'd1;
    localparam logic [1:0] REG_DST_W = 2'd2;
    localparam logic [1:0] REG_DST_H = 2'd3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CALC = 1'b1;

    typedef struct packed {
        logic          func;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [23:0]   rgb;
    } item_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [23:0]   rgb;
    } result_t;
endpackage
`default_nettype wire

/* rtl/bis_fifo.sv */
// Two-entry queue between the front and back parts of the scaler.
// Depends on bis_pkg.
`default_nettype none
module bis_fifo (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            wr_en,
    input  bis_pkg::item_t wr_data,
    output logic           full,
    output logic           empty,
    input  wire            rd_en,
    output bis_pkg::item_t rd_data
);
    import bis_pkg::*;
    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_data = mem_reg[rp_reg];

    // store entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end
endmodule
`default_nettype wire

/* rtl/bis_front.sv */
// Front part: configuration registers, input acceptance and load/compute classing.
// Depends on bis_pkg.
`default_nettype none
module bis_front (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_valid,
    output logic             cfg_ready,
    input  wire  [1:0]       cfg_index,
    input  wire  [31:0]      cfg_data,
    input  wire              valid,
    output logic             stall,
    input  wire              func,
    input  wire  [11:0]      x_coord,
    input  wire  [11:0]      y_coord,
    input  wire  [7:0]       red_in,
    input  wire  [7:0]       green_in,
    input  wire  [7:0]       blue_in,
    input  wire              q_full,
    output logic             q_wr,
    output bis_pkg::item_t   q_data,
    output logic [9:0]       sw,
    output logic [9:0]       sh,
    output logic [11:0]      dw,
    output logic [11:0]      dh
);
    import bis_pkg::*;
    logic [SWW-1:0] src_w_reg, src_h_reg;
    logic [DWW-1:0] dst_w_reg, dst_h_reg;

    assign cfg_ready = 1'b1;
    assign stall     = q_full;
    assign q_wr      = valid && !q_full;
    assign q_data    = '{func: func, x: x_coord, y: y_coord,
                         rgb: {red_in, green_in, blue_in}};

    // clamp sizes to legal ranges
    always_comb
    begin
        if (src_w_reg == '0) sw = 10'd1;
        else if (src_w_reg > SWW'(MAX_SRC_WIDTH)) sw = SWW'(MAX_SRC_WIDTH);
        else sw = src_w_reg;
        if (src_h_reg == '0) sh = 10'd1;
        else if (src_h_reg > SWW'(MAX_SRC_HEIGHT)) sh = SWW'(MAX_SRC_HEIGHT);
        else sh = src_h_reg;
        dw = (dst_w_reg == '0) ? 12'd1 : dst_w_reg;
        dh = (dst_h_reg == '0) ? 12'd1 : dst_h_reg;
    end

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= 10'd512;
            src_h_reg <= 10'd512;
            dst_w_reg <= 12'd512;
            dst_h_reg <= 12'd512;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SRC_W: src_w_reg <= cfg_data[SWW-1:0];
                REG_SRC_H: src_h_reg <= cfg_data[SWW-1:0];
                REG_DST_W: dst_w_reg <= cfg_data[DWW-1:0];
                REG_DST_H: dst_h_reg <= cfg_data[DWW-1:0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/bis_div.sv */
// Restoring divider, one quotient bit per cycle, for coordinate mapping.
// Depends on bis_pkg.
`default_nettype none
module bis_div (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire  [bis_pkg::NW-1:0]     num,
    input  wire  [11:0]                den,
    output logic                       done,
    output logic [bis_pkg::QW-1:0]     quo
);
    import bis_pkg::*;
    localparam int CNTW = $clog2(NW + 1);
    logic [NW-1:0]   n_reg;
    logic [12:0]     r_reg;
    logic [11:0]     d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic [12:0]     r_sh;
    logic            ge;

    assign r_sh = {r_reg[11:0], n_reg[NW-1]};
    assign ge   = r_sh >= {1'b0, d_reg};
    assign quo  = n_reg[QW-1:0];

    // shift one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
            n_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                n_reg    <= num;
                d_reg    <= den;
                r_reg    <= '0;
                cnt_reg  <= CNTW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                r_reg   <= ge ? r_sh - {1'b0, d_reg} : r_sh;
                n_reg   <= {n_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/bis_back.sv */
// Back part: frame memory, coordinate mapping, four neighbour reads and weighted sum.
// Depends on bis_pkg and bis_div.
`default_nettype none
module bis_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_empty,
    input  bis_pkg::item_t      q_data,
    output logic                q_rd,
    input  wire  [9:0]          sw,
    input  wire  [9:0]          sh,
    input  wire  [11:0]         dw,
    input  wire  [11:0]         dh,
    output logic                out_valid,
    input  wire                 out_stall,
    output bis_pkg::result_t    out_data
);
    import bis_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_DX = 4'd1, S_WX = 4'd2, S_DY = 4'd3,
                           S_WY = 4'd4, S_RD = 4'd5, S_ACC = 4'd6, S_OUT = 4'd7,
                           S_MX = 4'd8, S_MY = 4'd9;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int WW  = 2 * FRAC_BITS + 1;
    localparam int ACW = WW + 10;

    logic [23:0]          mem [MAX_SRC_WIDTH * MAX_SRC_HEIGHT];
    logic [3:0]           st_reg;
    item_t                it_reg;
    logic [XW-1:0]        x0_reg, x1_reg;
    logic [YW-1:0]        y0_reg, y1_reg;
    logic [FRAC_BITS:0]   fx_reg, fy_reg;
    logic [2:0]           rc_reg;
    logic [23:0]          rd_reg;
    logic [AW-1:0]        ra;
    logic [ACW-1:0]       acc_r_reg, acc_g_reg, acc_b_reg;
    logic [WW-1:0]        w_reg;
    logic                 dv_start;
    logic [NW-1:0]        dv_num;
    logic [11:0]          dv_den;
    logic                 dv_done;
    logic [QW-1:0]        dv_q;
    logic [QW-FRAC_BITS-1:0] i0, i1;
    logic [FRAC_BITS:0]   fa, fb;
    logic [CW+SWW-1:0]    prod_reg;

    bis_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num),
                   .den(dv_den), .done(dv_done), .quo(dv_q));

    assign dv_num = NW'({prod_reg, {FRAC_BITS{1'b0}}});
    assign dv_den = (st_reg == S_DX) ? dw : dh;
    assign dv_start = (st_reg == S_DX || st_reg == S_DY) && !rc_reg[0];
    assign i0 = dv_q[QW-1:FRAC_BITS];
    assign i1 = i0 + 1'b1;
    assign q_rd = (st_reg == S_IDLE) && !q_empty;

    // choose neighbour address for the read in flight
    always_comb
    begin
        case (rc_reg[1:0])
            2'd0:    ra = {y0_reg, x0_reg};
            2'd1:    ra = {y0_reg, x1_reg};
            2'd2:    ra = {y1_reg, x0_reg};
            default: ra = {y1_reg, x1_reg};
        endcase
        fa = ONE[FRAC_BITS:0] - fx_reg;
        fb = ONE[FRAC_BITS:0] - fy_reg;
    end

    // load pixels into the frame memory, read the neighbours one at a time
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && !q_empty && q_data.func == FUNC_LOAD
            && q_data.x < CW'(MAX_SRC_WIDTH) && q_data.y < CW'(MAX_SRC_HEIGHT))
            mem[{q_data.y[YW-1:0], q_data.x[XW-1:0]}] <= q_data.rgb;
        rd_reg <= mem[ra];
    end

    // sequence one compute item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            out_valid <= 1'b0;
            rc_reg    <= '0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (!q_empty && q_data.func == FUNC_CALC)
                    begin
                        it_reg <= q_data;
                        st_reg <= S_MX;
                    end
                end
                S_MX:
                begin
                    prod_reg <= it_reg.x * sw;
                    rc_reg   <= '0;
                    st_reg   <= S_DX;
                end
                S_DX:
                begin
                    rc_reg <= 3'd1;
                    if (dv_done)
                    begin
                        x0_reg <= (i0 > (QW-FRAC_BITS)'(sw - 1'b1)) ? XW'(sw - 1'b1)
                                                                     : XW'(i0);
                        x1_reg <= (i1 > (QW-FRAC_BITS)'(sw - 1'b1)) ? XW'(sw - 1'b1)
                                                                     : XW'(i1);
                        fx_reg <= {1'b0, dv_q[FRAC_BITS-1:0]};
                        st_reg <= S_MY;
                    end
                end
                S_MY:
                begin
                    prod_reg <= it_reg.y * sh;
                    rc_reg   <= '0;
                    st_reg   <= S_DY;
                end
                S_DY:
                begin
                    rc_reg <= 3'd1;
                    if (dv_done)
                    begin
                        y0_reg <= (i0 > (QW-FRAC_BITS)'(sh - 1'b1)) ? YW'(sh - 1'b1)
                                                                     : YW'(i0);
                        y1_reg <= (i1 > (QW-FRAC_BITS)'(sh - 1'b1)) ? YW'(sh - 1'b1)
                                                                     : YW'(i1);
                        fy_reg <= {1'b0, dv_q[FRAC_BITS-1:0]};
                        rc_reg <= '0;
                        acc_r_reg <= '0;
                        acc_g_reg <= '0;
                        acc_b_reg <= '0;
                        st_reg <= S_WX;
                    end
                end
                S_WX:
                begin
                    // weight for the neighbour being read
                    case (rc_reg[1:0])
                        2'd0:    w_reg <= WW'(fa * fb);
                        2'd1:    w_reg <= WW'(fx_reg * fb);
                        2'd2:    w_reg <= WW'(fa * fy_reg);
                        default: w_reg <= WW'(fx_reg * fy_reg);
                    endcase
                    st_reg <= S_RD;
                end
                S_RD:
                    st_reg <= S_ACC;
                S_ACC:
                begin
                    acc_r_reg <= acc_r_reg + ACW'(rd_reg[23:16] * w_reg);
                    acc_g_reg <= acc_g_reg + ACW'(rd_reg[15:8] * w_reg);
                    acc_b_reg <= acc_b_reg + ACW'(rd_reg[7:0] * w_reg);
                    if (rc_reg == 3'd3)
                        st_reg <= S_WY;
                    else
                    begin
                        rc_reg <= rc_reg + 1'b1;
                        st_reg <= S_WX;
                    end
                end
                S_WY:
                begin
                    out_data.x   <= it_reg.x;
                    out_data.y   <= it_reg.y;
                    out_data.rgb <= {acc_r_reg[2*FRAC_BITS +: 8],
                                     acc_g_reg[2*FRAC_BITS +: 8],
                                     acc_b_reg[2*FRAC_BITS +: 8]};
                    out_valid    <= 1'b1;
                    st_reg       <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        st_reg    <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/bilinear_image_scaler.sv */
// Bilinear image scaler top level: front, two-entry queue, back.
// A load passes through the queue and is written into the frame memory when the back part
// is idle; a compute result is presented after the bit-serial divider maps each axis in
// turn and four serial neighbour reads are weighted and summed; out_stall holds the result.
// Throughput: one load per cycle while the back part is idle; one compute item at a time.
// Reset: rst_n asynchronous, active low; sizes reset to 512, frame memory undefined.
`default_nettype none
module bilinear_image_scaler (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         func,
    input  wire  [11:0] x_coord,
    input  wire  [11:0] y_coord,
    input  wire  [7:0]  red_in,
    input  wire  [7:0]  green_in,
    input  wire  [7:0]  blue_in,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [11:0] dest_x,
    output logic [11:0] dest_y,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out
);
    import bis_pkg::*;
    item_t       wd, rd;
    result_t     res;
    logic        q_wr, q_full, q_empty, q_rd;
    logic [9:0]  sw, sh;
    logic [11:0] dw, dh;

    bis_front u_front (.clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .valid(in_valid), .stall(in_stall), .func(func), .x_coord(x_coord),
        .y_coord(y_coord), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .q_full(q_full), .q_wr(q_wr), .q_data(wd), .sw(sw), .sh(sh), .dw(dw), .dh(dh));

    bis_fifo u_fifo (.clk(clk), .rst_n(rst_n), .wr_en(q_wr), .wr_data(wd),
        .full(q_full), .empty(q_empty), .rd_en(q_rd), .rd_data(rd));

    bis_back u_back (.clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(rd),
        .q_rd(q_rd), .sw(sw), .sh(sh), .dw(dw), .dh(dh), .out_valid(out_valid),
        .out_stall(out_stall), .out_data(res));

    assign dest_x    = res.x;
    assign dest_y    = res.y;
    assign red_out   = res.rgb[23:16];
    assign green_out = res.rgb[15:8];
    assign blue_out  = res.rgb[7:0];
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Testbench for the bilinear image scaler: directed table, then randomised phases per size set.
// Checks each output pixel against an in-bench interpolation predictor and a shadow frame store.
// Depends on bis_pkg and the bilinear_image_scaler RTL.
`timescale 1ns / 100ps

module testbench;
    import bis_pkg::*;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int SETTLE_CYCLES = 200;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [11:0] x_coord;
    logic [11:0] y_coord;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;

    // Shadow state of the scaler
    bit [23:0]   shadow_px [0:STORE_DEPTH-1];
    bit          px_loaded [0:STORE_DEPTH-1];
    int unsigned cur_src_w;
    int unsigned cur_src_h;
    int unsigned cur_dst_w;
    int unsigned cur_dst_h;

    result_t     pending_px[$];
    int          error_count;
    int          loads_sent;
    int          pixels_checked;
    int          burst_left;

    typedef struct {
        logic        fn;
        logic [11:0] x;
        logic [11:0] y;
        logic [23:0] rgb;
        bit          typed;
        logic [23:0] want;
    } directed_row_t;

    bilinear_image_scaler DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .x_coord(x_coord), .y_coord(y_coord),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .dest_x(dest_x), .dest_y(dest_y),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Map one destination coordinate to two clamped source indices and a fraction
    function automatic void map_coord(input int unsigned d, input int unsigned s,
                                      input int unsigned dsz, output int unsigned i0,
                                      output int unsigned i1, output int unsigned frac);
        longint unsigned pos;
        pos  = ((longint'(d) * s) << FRAC_BITS) / dsz;
        i0   = int'(pos >> FRAC_BITS);
        frac = int'(pos & ((64'd1 << FRAC_BITS) - 1));
        i1   = i0 + 1;
        if (i0 > s - 1) i0 = s - 1;
        if (i1 > s - 1) i1 = s - 1;
    endfunction

    function automatic int unsigned eff_src_w();
        return (cur_src_w < 1) ? 1 : (cur_src_w > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : cur_src_w;
    endfunction

    function automatic int unsigned eff_src_h();
        return (cur_src_h < 1) ? 1 : (cur_src_h > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : cur_src_h;
    endfunction

    // Weighted sum of the four neighbours, channel by channel, truncated
    function automatic logic [23:0] interpolate(input int unsigned x, input int unsigned y);
        int unsigned     x0, x1, fx, y0, y1, fy;
        longint unsigned one, w00, w10, w01, w11, acc;
        bit [23:0]       p00, p10, p01, p11;
        logic [23:0]     res;
        map_coord(x, eff_src_w(), (cur_dst_w == 0) ? 1 : cur_dst_w, x0, x1, fx);
        map_coord(y, eff_src_h(), (cur_dst_h == 0) ? 1 : cur_dst_h, y0, y1, fy);
        one = 64'd1 << FRAC_BITS;
        w00 = (one - fx) * (one - fy);
        w10 = fx * (one - fy);
        w01 = (one - fx) * fy;
        w11 = longint'(fx) * fy;
        p00 = shadow_px[y0 * MAX_SRC_WIDTH + x0];
        p10 = shadow_px[y0 * MAX_SRC_WIDTH + x1];
        p01 = shadow_px[y1 * MAX_SRC_WIDTH + x0];
        p11 = shadow_px[y1 * MAX_SRC_WIDTH + x1];
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = p00[ch*8 +: 8] * w00 + p10[ch*8 +: 8] * w10 +
                  p01[ch*8 +: 8] * w01 + p11[ch*8 +: 8] * w11;
            res[ch*8 +: 8] = 8'(acc >> (2 * FRAC_BITS));
        end
        return res;
    endfunction

    // Drive one transaction, hold it until accepted, then update the shadow state
    task automatic send_item(input logic fn, input logic [11:0] x, input logic [11:0] y,
                             input logic [23:0] rgb, input bit typed, input logic [23:0] want);
        result_t r;
        int      gap;
        @(negedge clk);
        in_valid <= 1'b1;
        func     <= fn;
        x_coord  <= x;
        y_coord  <= y;
        red_in   <= rgb[23:16];
        green_in <= rgb[15:8];
        blue_in  <= rgb[7:0];
        do @(posedge clk); while (in_stall);
        if (fn == FUNC_LOAD)
        begin
            loads_sent++;
            if (x < MAX_SRC_WIDTH && y < MAX_SRC_HEIGHT)
            begin
                shadow_px[y * MAX_SRC_WIDTH + x] = rgb;
                px_loaded[y * MAX_SRC_WIDTH + x] = 1'b1;
            end
        end
        else
        begin
            r.x   = x;
            r.y   = y;
            r.rgb = typed ? want : interpolate(x, y);
            pending_px.push_back(r);
        end
        // Bursts with random gaps; some bursts run back to back
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Ask for a destination pixel, first loading any neighbour not yet written
    task automatic request_pixel(input logic [11:0] x, input logic [11:0] y,
                                 input bit typed, input logic [23:0] want);
        int unsigned x0, x1, fx, y0, y1, fy;
        int unsigned nx[4];
        int unsigned ny[4];
        map_coord(x, eff_src_w(), (cur_dst_w == 0) ? 1 : cur_dst_w, x0, x1, fx);
        map_coord(y, eff_src_h(), (cur_dst_h == 0) ? 1 : cur_dst_h, y0, y1, fy);
        nx = '{x0, x1, x0, x1};
        ny = '{y0, y0, y1, y1};
        for (int k = 0; k < 4; k++)
            if (!px_loaded[ny[k] * MAX_SRC_WIDTH + nx[k]])
                send_item(FUNC_LOAD, 12'(nx[k]), 12'(ny[k]), 24'($urandom), 1'b0, '0);
        send_item(FUNC_CALC, x, y, 24'($urandom), typed, want);
    endtask

    // Hold off until every pixel is out and the back end has settled
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_px.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SRC_W: cur_src_w = value[9:0];
            REG_SRC_H: cur_src_h = value[9:0];
            REG_DST_W: cur_dst_w = value[11:0];
            REG_DST_H: cur_dst_h = value[11:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Set all four sizes; upper data bits carry noise that the block must drop
    task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                             input int unsigned dw, input int unsigned dh);
        write_reg(REG_SRC_W, {22'($urandom_range(0, 4194303)), sw[9:0]});
        write_reg(REG_SRC_H, {22'($urandom_range(0, 4194303)), sh[9:0]});
        write_reg(REG_DST_W, {20'($urandom_range(0, 1048575)), dw[11:0]});
        write_reg(REG_DST_H, {20'($urandom_range(0, 1048575)), dh[11:0]});
    endtask

    // Mostly well-formed loads and requests inside the sizes, some anywhere
    task automatic random_phase(input int count);
        int unsigned x, y;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                else
                begin
                    x = $urandom_range(0, eff_src_w() - 1);
                    y = $urandom_range(0, eff_src_h() - 1);
                end
                send_item(FUNC_LOAD, 12'(x), 12'(y), 24'($urandom), 1'b0, '0);
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                else
                begin
                    x = $urandom_range(0, (cur_dst_w == 0) ? 0 : cur_dst_w - 1);
                    y = $urandom_range(0, (cur_dst_h == 0) ? 0 : cur_dst_h - 1);
                end
                request_pixel(12'(x), 12'(y), 1'b0, '0);
            end
        end
    endtask

    // Receiver stall pattern: calm, light and heavy stretches
    initial
    begin
        int mode;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat (64)
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    default: out_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    // Compare each accepted pixel with the oldest prediction
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_px.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected pixel x=%0d y=%0d rgb=%06h", $time,
                         dest_x, dest_y, {red_out, green_out, blue_out});
            end
            else
            begin
                e = pending_px.pop_front();
                pixels_checked++;
                if (dest_x !== e.x || dest_y !== e.y)
                begin
                    error_count++;
                    $display("%0t: coordinates expected (%0d,%0d) actual (%0d,%0d)",
                             $time, e.x, e.y, dest_x, dest_y);
                end
                if (red_out !== e.rgb[23:16])
                begin
                    error_count++;
                    $display("%0t: red at (%0d,%0d) expected %02h actual %02h",
                             $time, e.x, e.y, e.rgb[23:16], red_out);
                end
                if (green_out !== e.rgb[15:8])
                begin
                    error_count++;
                    $display("%0t: green at (%0d,%0d) expected %02h actual %02h",
                             $time, e.x, e.y, e.rgb[15:8], green_out);
                end
                if (blue_out !== e.rgb[7:0])
                begin
                    error_count++;
                    $display("%0t: blue at (%0d,%0d) expected %02h actual %02h",
                             $time, e.x, e.y, e.rgb[7:0], blue_out);
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        directed_row_t rows[$];
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SRC_W;
        cfg_data  = '0;
        in_valid  = 1'b0;
        func      = FUNC_LOAD;
        x_coord   = '0;
        y_coord   = '0;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        error_count    = 0;
        loads_sent     = 0;
        pixels_checked = 0;
        burst_left     = 0;
        cur_src_w = 512;
        cur_src_h = 512;
        cur_dst_w = 512;
        cur_dst_h = 512;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: sizes at reset, corners, ignored loads, requests past the edge
        rows = '{
            '{FUNC_LOAD, 12'd0,    12'd0,    24'hFFFFFF, 1'b0, 24'h0},
            '{FUNC_LOAD, 12'd1,    12'd0,    24'h000000, 1'b0, 24'h0},
            '{FUNC_LOAD, 12'd0,    12'd1,    24'h000000, 1'b0, 24'h0},
            '{FUNC_LOAD, 12'd1,    12'd1,    24'h000000, 1'b0, 24'h0},
            '{FUNC_CALC, 12'd0,    12'd0,    24'hABCDEF, 1'b1, 24'hFFFFFF},
            '{FUNC_LOAD, 12'd511,  12'd511,  24'h123456, 1'b0, 24'h0},
            '{FUNC_CALC, 12'd511,  12'd511,  24'h000000, 1'b1, 24'h123456},
            '{FUNC_CALC, 12'd4095, 12'd4095, 24'hFFFFFF, 1'b1, 24'h123456},
            '{FUNC_LOAD, 12'd4095, 12'd4095, 24'hFFFFFF, 1'b0, 24'h0},
            '{FUNC_LOAD, 12'd512,  12'd0,    24'hFFFFFF, 1'b0, 24'h0},
            '{FUNC_LOAD, 12'd0,    12'd512,  24'hFFFFFF, 1'b0, 24'h0},
            '{FUNC_CALC, 12'd4095, 12'd4095, 24'h000000, 1'b1, 24'h123456},
            '{FUNC_LOAD, 12'd511,  12'd0,    24'hA5A5A5, 1'b0, 24'h0},
            '{FUNC_CALC, 12'd511,  12'd0,    24'h5A5A5A, 1'b1, 24'hA5A5A5},
            '{FUNC_CALC, 12'd0,    12'd4095, 24'h000000, 1'b0, 24'h0},
            '{FUNC_CALC, 12'd4095, 12'd0,    24'h000000, 1'b0, 24'h0},
            '{FUNC_CALC, 12'd255,  12'd129,  24'h000000, 1'b0, 24'h0}
        };
        foreach (rows[i])
        begin
            if (rows[i].fn == FUNC_LOAD)
                send_item(FUNC_LOAD, rows[i].x, rows[i].y, rows[i].rgb, 1'b0, '0);
            else
                request_pixel(rows[i].x, rows[i].y, rows[i].typed, rows[i].want);
        end
        random_phase(80);
        wait_idle();

        // Size sets: extremes, clamped values, then random small frames
        set_sizes(1, 1, 1, 1);
        random_phase(100);
        wait_idle();
        set_sizes(512, 512, 4095, 4095);
        random_phase(80);
        wait_idle();
        set_sizes(0, 0, 0, 0);
        random_phase(80);
        wait_idle();
        set_sizes(1023, 1023, 7, 3);
        random_phase(100);
        wait_idle();
        set_sizes(4, 3, 9, 7);
        random_phase(100);
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            set_sizes($urandom_range(1, 32), $urandom_range(1, 32),
                      $urandom_range(1, 64), $urandom_range(1, 64));
            random_phase(100);
        end
        wait_idle();

        $display("Covered %0d source loads and %0d checked pixels over 10 size sets,",
                 loads_sent, pixels_checked);
        $display("with clamped sizes, edge neighbours and requests past the destination.");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

/* filelist.f */
rtl/bis_pkg.sv
rtl/bis_fifo.sv
rtl/bis_front.sv
rtl/bis_div.sv
rtl/bis_back.sv
rtl/bilinear_image_scaler.sv
verif/testbench.sv
